FILE: rtl/multibyte_integer_alu_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the multibyte integer ALU
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef MULTIBYTE_INTEGER_ALU_TOP_MACROS_SVH
`define MULTIBYTE_INTEGER_ALU_TOP_MACROS_SVH

// antecedent implies consequent on the next edge
`define MIA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: label");

// antecedent implies consequent on the same edge
`define MIA_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: label");

`endif

FILE: rtl/mia_pkg.sv
// ----------------------------------------------------------------------------
// Multibyte integer ALU package
// Opcodes, widths and command types shared by controller and datapath.
// ----------------------------------------------------------------------------
package mia_pkg;

  localparam int WIDTH_BYTES_DEF = 8;
  localparam int FIELD_W = 64;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
    OP_CMP = 4'd4, OP_AND = 4'd5, OP_OR = 4'd6, OP_XOR = 4'd7,
    OP_NOT = 4'd8, OP_SHL = 4'd9, OP_SHR = 4'd10, OP_ROL = 4'd11,
    OP_ROR = 4'd12, OP_INC = 4'd13, OP_DEC = 4'd14, OP_NONE = 4'd15
  } op_t;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic iterative;
    logic last_step;
  } dp_sts_t;

endpackage

FILE: rtl/mia_datapath.sv
// ----------------------------------------------------------------------------
// Multibyte integer ALU datapath
// Operand registers, shared shift-add / shift-subtract unit, result register.
// ----------------------------------------------------------------------------
module mia_datapath #(
  parameter int WIDTH_BYTES = mia_pkg::WIDTH_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mia_pkg::dp_cmd_t              cmd,
  output mia_pkg::dp_sts_t              sts,
  input  logic [3:0]                    req_type,
  input  logic [mia_pkg::FIELD_W-1:0]   operand_a,
  input  logic [mia_pkg::FIELD_W-1:0]   operand_b,
  input  logic [5:0]                    shift_amount,
  output logic [mia_pkg::FIELD_W-1:0]   result,
  output logic [mia_pkg::FIELD_W-1:0]   remainder,
  output logic                          carry_out,
  output logic [1:0]                    compare,
  output logic                          divide_by_zero
);

  localparam int W  = 8 * WIDTH_BYTES;
  localparam int CW = $clog2(W + 1);
  localparam int FW = mia_pkg::FIELD_W;

  mia_pkg::op_t op;
  logic [W-1:0] a;
  logic [W-1:0] b;
  logic [W-1:0] acc;
  logic [W-1:0] rr;
  logic [CW-1:0] cnt;
  logic [5:0]   n;
  logic [W-1:0] ain;
  logic [W-1:0] bin;

  logic [W:0]   sum;
  logic [W:0]   dif;
  logic [W-1:0] rshift;
  logic [W:0]   trial;
  logic [W-1:0] lres;
  logic [W-1:0] rlres;
  logic [W-1:0] rrres;
  logic         lcarry;
  logic [1:0]   lcmp;
  logic [W-1:0] one;
  logic [6:0]   nred;
  logic [CW-1:0] nmod;
  logic [CW-1:0] nror;

  assign ain = W'(operand_a);
  assign bin = W'(operand_b);

  assign sts.iterative = (op == mia_pkg::OP_MUL) || (op == mia_pkg::OP_DIV);
  assign sts.last_step = (cnt == CW'(W - 1));

  // reduce the rotate count below the width (widths of 16 bits and wider)
  always_comb begin
    nred = {1'b0, n};
    for (int k = 0; k < 4; k++) begin
      if ((W < 64) && (nred >= 7'(W))) nred = nred - 7'(W);
    end
  end

  assign one   = W'(1);
  assign sum   = {1'b0, a} + {1'b0, (op == mia_pkg::OP_INC) ? one : b};
  assign dif   = {1'b0, a} - {1'b0, (op == mia_pkg::OP_DEC) ? one : b};
  assign rshift = {rr[W-2:0], a[W-1]};
  assign trial = {rr[W-1], rshift} - {1'b0, b};
  assign nmod  = CW'(nred);
  assign nror  = (nmod == '0) ? '0 : CW'(W) - nmod;
  assign rlres = (a << nmod) | (a >> (CW'(W) - nmod));
  assign rrres = (a << nror) | (a >> (CW'(W) - nror));

  always_comb begin
    lres   = '0;
    lcarry = 1'b0;
    lcmp   = 2'b00;
    unique case (op)
      mia_pkg::OP_ADD, mia_pkg::OP_INC: begin
        lres = sum[W-1:0];
        lcarry = sum[W];
      end
      mia_pkg::OP_SUB, mia_pkg::OP_DEC: begin
        lres = dif[W-1:0];
        lcarry = dif[W];
      end
      mia_pkg::OP_MUL: lres = acc;
      mia_pkg::OP_DIV: lres = acc;
      mia_pkg::OP_CMP: lcmp = (a < b) ? 2'b11 : ((a > b) ? 2'b01 : 2'b00);
      mia_pkg::OP_AND: lres = a & b;
      mia_pkg::OP_OR:  lres = a | b;
      mia_pkg::OP_XOR: lres = a ^ b;
      mia_pkg::OP_NOT: lres = ~a;
      mia_pkg::OP_SHL: lres = (32'(n) >= W) ? '0 : a << n;
      mia_pkg::OP_SHR: lres = (32'(n) >= W) ? '0 : a >> n;
      mia_pkg::OP_ROL: lres = (nmod == '0) ? a : rlres;
      mia_pkg::OP_ROR: lres = (nror == '0) ? a : rrres;
      default: lres = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= mia_pkg::op_t'(req_type);
      a   <= ain;
      b   <= bin;
      n   <= shift_amount;
      acc <= '0;
      rr  <= '0;
      cnt <= '0;
    end else if (cmd.step) begin
      cnt <= cnt + CW'(1);
      if (op == mia_pkg::OP_MUL) begin
        if (b[0]) acc <= (acc + a);
        a <= a << 1;
        b <= b >> 1;
      end else begin
        a <= a << 1;
        if (rr[W-1] || !trial[W]) begin
          rr  <= trial[W-1:0];
          acc <= {acc[W-2:0], 1'b1};
        end else begin
          rr  <= rshift;
          acc <= {acc[W-2:0], 1'b0};
        end
      end
    end
    if (rst) begin
      result    <= '0;
      remainder <= '0;
      carry_out <= 1'b0;
      compare   <= 2'b00;
      divide_by_zero <= 1'b0;
    end else if (cmd.finish) begin
      result    <= FW'(lres);
      remainder <= (op == mia_pkg::OP_DIV) ? FW'(rr) : '0;
      carry_out <= lcarry;
      compare   <= lcmp;
      divide_by_zero <= (op == mia_pkg::OP_DIV) && (b == '0);
    end
  end

endmodule

FILE: rtl/mia_control.sv
// ----------------------------------------------------------------------------
// Multibyte integer ALU controller
// Request handshake, iteration sequencing and output register valid.
// ----------------------------------------------------------------------------
module mia_control (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  output logic             m_tvalid,
  input  logic             m_tready,
  output mia_pkg::dp_cmd_t cmd,
  input  mia_pkg::dp_sts_t sts
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load = 1'b1;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (sts.iterative && !sts.last_step) begin
          cmd.step = 1'b1;
        end else if (sts.iterative) begin
          cmd.step = 1'b1;
          state_next = ST_DONE;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

endmodule

FILE: rtl/multibyte_integer_alu_top.sv
// ----------------------------------------------------------------------------
// Multibyte integer ALU top level
// Unsigned ALU on WIDTH_BYTES-byte operands with a stream request/result port.
// ----------------------------------------------------------------------------
// One request at a time. Multiply and divide run one operand bit per cycle in
// a shared shift-add/subtract unit; every other operation skips the
// iteration. The result register frees the controller once the result is
// loaded into it.
module multibyte_integer_alu_top #(
  parameter int WIDTH_BYTES = mia_pkg::WIDTH_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [143:0] s_tdata,   // req_type[3:0], operand_a, operand_b, shift_amount[5:0], pad
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [135:0] m_tdata    // result, remainder, carry_out, compare[1:0], divide_by_zero, pad
);

  mia_pkg::dp_cmd_t cmd;
  mia_pkg::dp_sts_t sts;
  logic [63:0] result;
  logic [63:0] remainder;
  logic        carry_out;
  logic [1:0]  compare;
  logic        divide_by_zero;

  mia_control u_ctrl (
    .clk, .rst, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .cmd, .sts
  );

  mia_datapath #(.WIDTH_BYTES(WIDTH_BYTES)) u_dp (
    .clk, .rst, .cmd, .sts,
    .req_type(s_tdata[3:0]),
    .operand_a(s_tdata[67:4]),
    .operand_b(s_tdata[131:68]),
    .shift_amount(s_tdata[137:132]),
    .result, .remainder, .carry_out, .compare, .divide_by_zero
  );

  assign m_tdata = {4'b0000, divide_by_zero, compare, carry_out, remainder, result};

endmodule

FILE: rtl/mia_checker.sv
// ----------------------------------------------------------------------------
// Multibyte integer ALU port checker
// Port-level timing properties, bound to the top level.
// ----------------------------------------------------------------------------
`include "multibyte_integer_alu_top_macros.svh"

module mia_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [135:0] m_tdata
);

  `MIA_ASSERT_NEXT(a_busy_after_req, clk, rst, s_tvalid && s_tready, !s_tready)
  `MIA_ASSERT_NEXT(a_no_result_after_req, clk, rst, s_tvalid && s_tready && (!m_tvalid || m_tready), !m_tvalid)
  `MIA_ASSERT_NEXT(a_hold_result, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `MIA_ASSERT_SAME(a_cmp_code, clk, rst, m_tvalid, m_tdata[130:129] != 2'b10)

endmodule

bind multibyte_integer_alu_top mia_checker u_chk (
  .clk, .rst, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata
);

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// Multibyte integer ALU testbench
// Drives directed and random requests through the stream port under random
// bursts and stalls, and checks every result against a behavioral predictor.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [3:0]  op;
    logic [63:0] a;
    logic [63:0] b;
    logic [5:0]  n;
  } alu_req_t;

  typedef struct packed {
    logic [63:0] result;
    logic [63:0] remainder;
    logic        carry_out;
    logic [1:0]  compare;
    logic        divide_by_zero;
  } alu_res_t;

  typedef struct {
    mia_pkg::op_t op;
    logic [63:0] a;
    logic [63:0] b;
    logic [5:0]  n;
    bit          typed;
    logic [63:0] result;
    logic [63:0] remainder;
    logic        carry_out;
    logic [1:0]  compare;
    logic        divide_by_zero;
  } vector_t;

  localparam logic [63:0] MAX = '1;
  localparam int RANDOM_ITEMS = 400;
  localparam int IDLE_LIMIT = 3000;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [143:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [135:0] m_tdata;

  alu_res_t pending_results[$];
  int       errors = 0;
  int       sent = 0;
  int       idle_cycles = 0;
  bit       hold_done = 0;

  multibyte_integer_alu_top dut (.*);

  always #2 clk = ~clk;

  function automatic logic [143:0] pack_req(mia_pkg::op_t op, logic [63:0] a,
                                            logic [63:0] b, logic [5:0] n);
    return {6'b000000, n, b, a, op};
  endfunction

  function automatic logic [63:0] rotl(logic [63:0] a, int k);
    if (k == 0) return a;
    return (a << k) | (a >> (64 - k));
  endfunction

  function automatic alu_res_t compute_alu(logic [143:0] d);
    alu_res_t r;
    mia_pkg::op_t op;
    logic [63:0] a, b;
    logic [5:0] n;
    logic [64:0] wide;
    op = mia_pkg::op_t'(d[3:0]);
    a = d[67:4];
    b = d[131:68];
    n = d[137:132];
    r = '{default: '0};
    case (op)
      mia_pkg::OP_ADD: begin wide = {1'b0, a} + {1'b0, b}; r.result = wide[63:0];
        r.carry_out = wide[64]; end
      mia_pkg::OP_SUB: begin r.result = a - b; r.carry_out = a < b; end
      mia_pkg::OP_MUL: r.result = a * b;
      mia_pkg::OP_DIV: begin
        if (b == 0) begin
          r.divide_by_zero = 1; r.result = MAX; r.remainder = a;
        end else begin
          r.result = a / b; r.remainder = a % b;
        end
      end
      mia_pkg::OP_CMP: r.compare = (a < b) ? 2'b11 : (a > b) ? 2'b01 : 2'b00;
      mia_pkg::OP_AND: r.result = a & b;
      mia_pkg::OP_OR:  r.result = a | b;
      mia_pkg::OP_XOR: r.result = a ^ b;
      mia_pkg::OP_NOT: r.result = ~a;
      mia_pkg::OP_SHL: r.result = a << n;
      mia_pkg::OP_SHR: r.result = a >> n;
      mia_pkg::OP_ROL: r.result = rotl(a, n);
      mia_pkg::OP_ROR: r.result = rotl(a, (64 - n) % 64);
      mia_pkg::OP_INC: begin r.result = a + 1; r.carry_out = a == MAX; end
      mia_pkg::OP_DEC: begin r.result = a - 1; r.carry_out = a == 0; end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] rand_operand();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return MAX;
      2: return 64'($urandom_range(0, 255));
      3: return 64'(1) << $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  vector_t directed[] = '{
    '{mia_pkg::OP_ADD, MAX, 64'd1, 6'd0, 1, 64'd0, 64'd0, 1'b1, 2'b00, 1'b0},
    '{mia_pkg::OP_ADD, 64'd0, 64'd0, 6'd0, 1, 64'd0, 64'd0, 1'b0, 2'b00, 1'b0},
    '{mia_pkg::OP_SUB, 64'd0, 64'd1, 6'd0, 1, MAX, 64'd0, 1'b1, 2'b00, 1'b0},
    '{mia_pkg::OP_SUB, MAX, MAX, 6'd0, 1, 64'd0, 64'd0, 1'b0, 2'b00, 1'b0},
    '{mia_pkg::OP_MUL, MAX, MAX, 6'd0, 1, 64'd1, 64'd0, 1'b0, 2'b00, 1'b0},
    '{mia_pkg::OP_MUL, 64'h1234_5678, 64'h9abc_def0, 6'd0, 0, '0, '0, 0, '0, 0},
    '{mia_pkg::OP_DIV, 64'd77, 64'd0, 6'd0, 1, MAX, 64'd77, 1'b0, 2'b00, 1'b1},
    '{mia_pkg::OP_DIV, MAX, 64'd1, 6'd0, 1, MAX, 64'd0, 1'b0, 2'b00, 1'b0},
    '{mia_pkg::OP_DIV, 64'd5, MAX, 6'd0, 1, 64'd0, 64'd5, 1'b0, 2'b00, 1'b0},
    '{mia_pkg::OP_DIV, MAX, 64'h8000_0000_0000_0001, 6'd0, 0, '0, '0, 0, '0, 0},
    '{mia_pkg::OP_CMP, 64'd0, MAX, 6'd0, 1, 64'd0, 64'd0, 1'b0, 2'b11, 1'b0},
    '{mia_pkg::OP_CMP, MAX, MAX, 6'd0, 1, 64'd0, 64'd0, 1'b0, 2'b00, 1'b0},
    '{mia_pkg::OP_CMP, MAX, 64'd0, 6'd0, 1, 64'd0, 64'd0, 1'b0, 2'b01, 1'b0},
    '{mia_pkg::OP_AND, MAX, 64'h0f0f_0f0f_0f0f_0f0f, 6'd0, 0, '0, '0, 0, '0, 0},
    '{mia_pkg::OP_OR, 64'hff00_0000_0000_0000, 64'h00ff, 6'd0, 0, '0, '0, 0, '0, 0},
    '{mia_pkg::OP_XOR, MAX, 64'h5555_5555_5555_5555, 6'd0, 0, '0, '0, 0, '0, 0},
    '{mia_pkg::OP_NOT, 64'd0, MAX, 6'd0, 1, MAX, 64'd0, 1'b0, 2'b00, 1'b0},
    '{mia_pkg::OP_SHL, MAX, 64'd0, 6'd63, 0, '0, '0, 0, '0, 0},
    '{mia_pkg::OP_SHR, MAX, 64'd0, 6'd15, 0, '0, '0, 0, '0, 0},
    '{mia_pkg::OP_ROL, 64'h8000_0000_0000_0001, 64'd0, 6'd0, 0, '0, '0, 0, '0, 0},
    '{mia_pkg::OP_ROR, 64'h8000_0000_0000_0001, 64'd0, 6'd1, 0, '0, '0, 0, '0, 0},
    '{mia_pkg::OP_INC, MAX, 64'd0, 6'd0, 1, 64'd0, 64'd0, 1'b1, 2'b00, 1'b0},
    '{mia_pkg::OP_DEC, 64'd0, 64'd0, 6'd0, 1, MAX, 64'd0, 1'b1, 2'b00, 1'b0},
    '{mia_pkg::OP_NONE, MAX, MAX, 6'd63, 1, 64'd0, 64'd0, 1'b0, 2'b00, 1'b0}
  };

  task automatic send_request(logic [143:0] d);
    s_tvalid <= 1;
    s_tdata  <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
    if ($urandom_range(0, 3) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      pending_results.push_back(compute_alu(s_tdata));
    end
  end

  always @(posedge clk) begin
    alu_res_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (m_tdata[63:0] !== exp_r.result) begin
          $error("result exp %h got %h", exp_r.result, m_tdata[63:0]); errors++;
        end
        if (m_tdata[127:64] !== exp_r.remainder) begin
          $error("remainder exp %h got %h", exp_r.remainder, m_tdata[127:64]); errors++;
        end
        if (m_tdata[128] !== exp_r.carry_out) begin
          $error("carry_out exp %b got %b", exp_r.carry_out, m_tdata[128]); errors++;
        end
        if (m_tdata[130:129] !== exp_r.compare) begin
          $error("compare exp %b got %b", exp_r.compare, m_tdata[130:129]); errors++;
        end
        if (m_tdata[131] !== exp_r.divide_by_zero) begin
          $error("divide_by_zero exp %b got %b", exp_r.divide_by_zero, m_tdata[131]);
          errors++;
        end
      end
    end
  end

  initial begin
    int hold;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!hold_done && sent >= 120) begin
        m_tready <= 0;
        for (hold = 0; hold < 400; hold++) @(posedge clk);
        hold_done = 1;
      end
      if ((sent / 50) % 2 == 1) m_tready <= 1;
      else m_tready <= ($urandom_range(0, 2) != 0);
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    vector_t v;
    alu_res_t typed_r;
    alu_res_t pred;
    mia_pkg::op_t op;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    foreach (directed[i]) begin
      v = directed[i];
      if (v.typed) begin
        typed_r = '{v.result, v.remainder, v.carry_out, v.compare, v.divide_by_zero};
        pred = compute_alu(pack_req(v.op, v.a, v.b, v.n));
        if (pred != typed_r) begin
          $error("directed row %0d: table and predictor disagree", i);
          errors++;
        end
      end
      send_request(pack_req(v.op, v.a, v.b, v.n));
    end
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 200) begin
        s_tvalid <= 0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
      end
      op = mia_pkg::op_t'($urandom_range(0, 15));
      send_request(pack_req(op, rand_operand(), rand_operand(), 6'($urandom_range(0, 63))));
    end
    s_tvalid <= 0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
